@@ rtl/core/bve_pkg.sv @@
// Shared types, constants and helpers for the byte-code instruction executor.
// Used by bve_alu and bytecode_vm_instruction_executor_core.
package bve_pkg;

    // Default sizes
    localparam int MEMORY_BYTES_DEF = 4096;
    localparam int STACK_DEPTH_DEF  = 16;
    localparam int PC_RESET         = 512;
    localparam int NUM_REGS         = 16;
    localparam logic [3:0] FLAG_REG = 4'hF;

    // Item operations
    localparam logic [1:0] OPER_WRITE = 2'd0;
    localparam logic [1:0] OPER_READ  = 2'd1;
    localparam logic [1:0] OPER_EXEC  = 2'd2;
    // Reserved code: changes nothing, reports the program counter only
    localparam logic [1:0] OPER_NOP   = 2'd3;

    // Status codes
    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_UNSUP     = 2'd1;
    localparam logic [1:0] STAT_OVERFLOW  = 2'd2;
    localparam logic [1:0] STAT_UNDERFLOW = 2'd3;

    // Instruction groups (top nibble)
    localparam logic [3:0] GRP_SYS         = 4'h0;
    localparam logic [3:0] GRP_JUMP        = 4'h1;
    localparam logic [3:0] GRP_CALL        = 4'h2;
    localparam logic [3:0] GRP_SKIP_EQ_IMM = 4'h3;
    localparam logic [3:0] GRP_SKIP_NE_IMM = 4'h4;
    localparam logic [3:0] GRP_SKIP_EQ_REG = 4'h5;
    localparam logic [3:0] GRP_LOAD_IMM    = 4'h6;
    localparam logic [3:0] GRP_ADD_IMM     = 4'h7;
    localparam logic [3:0] GRP_ALU         = 4'h8;
    localparam logic [3:0] GRP_SKIP_NE_REG = 4'h9;
    localparam logic [3:0] GRP_LOAD_INDEX  = 4'hA;
    localparam logic [3:0] GRP_JUMP_V0     = 4'hB;
    localparam logic [3:0] GRP_RANDOM      = 4'hC;
    localparam logic [3:0] GRP_MISC        = 4'hF;

    // Whole-word system instructions
    localparam logic [15:0] OPW_CLEAR  = 16'h00E0;
    localparam logic [15:0] OPW_RETURN = 16'h00EE;

    // ALU group sub-codes
    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    // Misc group sub-codes (low byte)
    localparam logic [7:0] MISC_GET_DELAY = 8'h07;
    localparam logic [7:0] MISC_SET_DELAY = 8'h15;
    localparam logic [7:0] MISC_SET_SOUND = 8'h18;
    localparam logic [7:0] MISC_ADD_INDEX = 8'h1E;
    localparam logic [7:0] MISC_FONT      = 8'h29;
    localparam logic [7:0] MISC_BCD       = 8'h33;
    localparam logic [7:0] MISC_SAVE      = 8'h55;
    localparam logic [7:0] MISC_LOAD      = 8'h65;

    // Decoded actions of one instruction
    typedef struct packed {
        logic [1:0]  status;
        logic        clear;
        logic        wr_vx;
        logic [7:0]  vx_val;
        logic        wr_flag;
        logic        flag_val;
        logic        push;
        logic        pop;
        logic        set_index;
        logic [11:0] index_val;
        logic        set_delay;
        logic        do_bcd;
        logic        do_save;
        logic        do_load;
    } exec_ctl_t;

    // Split a byte into hundreds, tens and ones, one nibble each
    function automatic logic [11:0] bcd_digits(input logic [7:0] v);
        logic [1:0]  h;
        logic [7:0]  r;
        logic [13:0] p;
        logic [3:0]  t;
        logic [7:0]  o;
        if (v >= 8'd200) begin
            h = 2'd2;
            r = v - 8'd200;
        end
        else if (v >= 8'd100) begin
            h = 2'd1;
            r = v - 8'd100;
        end
        else begin
            h = 2'd0;
            r = v;
        end
        // r < 100: multiply by 103/1024 gives r/10 exactly
        p = 14'(r) * 14'd103;
        t = p[13:10];
        o = r - 8'(t) * 8'd10;
        return {2'b00, h, t, o[3:0]};
    endfunction

endpackage

@@ rtl/core/bve_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bve_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/core/bve_alu.sv @@
// Instruction decode and ALU: turns one instruction word and its operands
// into the next program counter and a set of actions. Depends on bve_pkg.
module bve_alu
    import bve_pkg::*;
#(
    parameter int PC_W = 12
) (
    input  logic [15:0]     opcode,
    input  logic [7:0]      vx,
    input  logic [7:0]      vy,
    input  logic [PC_W-1:0] aux,
    input  logic [PC_W-1:0] pc,
    input  logic [11:0]     index,
    input  logic [11:0]     font_base,
    input  logic [7:0]      delay,
    input  logic [7:0]      random_byte,
    input  logic            stack_full,
    input  logic            stack_empty,
    output exec_ctl_t       ctl,
    output logic [PC_W-1:0] pc_next
);

    logic [3:0]      grp;
    logic [3:0]      sub;
    logic [7:0]      nn;
    logic [11:0]     nnn;
    logic [8:0]      sum;
    logic [12:0]     jv0;
    logic [PC_W-1:0] pc_step;
    logic [PC_W-1:0] pc_skip;

    assign grp     = opcode[15:12];
    assign sub     = opcode[3:0];
    assign nn      = opcode[7:0];
    assign nnn     = opcode[11:0];
    assign sum     = {1'b0, vx} + {1'b0, vy};
    assign jv0     = {1'b0, nnn} + 13'(aux[7:0]);
    assign pc_step = pc + PC_W'(2);
    assign pc_skip = pc + PC_W'(4);

    // Decode and compute
    always_comb
    begin
        ctl     = '0;
        pc_next = pc_step;
        case (grp)
            GRP_SYS:
            begin
                if (opcode == OPW_CLEAR)
                begin
                    ctl.clear = 1'b1;
                end
                else if (opcode == OPW_RETURN)
                begin
                    if (stack_empty)
                    begin
                        ctl.status = STAT_UNDERFLOW;
                    end
                    else
                    begin
                        ctl.pop = 1'b1;
                        pc_next = aux + PC_W'(2);
                    end
                end
                else
                begin
                    ctl.status = STAT_UNSUP;
                end
            end
            GRP_JUMP:        pc_next = PC_W'(nnn);
            GRP_CALL:
            begin
                if (stack_full)
                begin
                    ctl.status = STAT_OVERFLOW;
                end
                else
                begin
                    ctl.push = 1'b1;
                    pc_next  = PC_W'(nnn);
                end
            end
            GRP_SKIP_EQ_IMM: pc_next = (vx == nn) ? pc_skip : pc_step;
            GRP_SKIP_NE_IMM: pc_next = (vx != nn) ? pc_skip : pc_step;
            GRP_SKIP_EQ_REG: pc_next = (vx == vy) ? pc_skip : pc_step;
            GRP_SKIP_NE_REG: pc_next = (vx != vy) ? pc_skip : pc_step;
            GRP_LOAD_IMM:
            begin
                ctl.wr_vx  = 1'b1;
                ctl.vx_val = nn;
            end
            GRP_ADD_IMM:
            begin
                ctl.wr_vx  = 1'b1;
                ctl.vx_val = vx + nn;
            end
            GRP_ALU:
            begin
                ctl.wr_vx = 1'b1;
                case (sub)
                    ALU_MOV: ctl.vx_val = vy;
                    ALU_OR:  ctl.vx_val = vx | vy;
                    ALU_AND: ctl.vx_val = vx & vy;
                    ALU_XOR: ctl.vx_val = vx ^ vy;
                    ALU_ADD:
                    begin
                        ctl.vx_val   = sum[7:0];
                        ctl.wr_flag  = 1'b1;
                        ctl.flag_val = sum[8];
                    end
                    ALU_SUB:
                    begin
                        ctl.vx_val   = vx - vy;
                        ctl.wr_flag  = 1'b1;
                        ctl.flag_val = (vx >= vy);
                    end
                    ALU_SHR:
                    begin
                        ctl.vx_val   = {1'b0, vx[7:1]};
                        ctl.wr_flag  = 1'b1;
                        ctl.flag_val = vx[0];
                    end
                    ALU_SUBN:
                    begin
                        ctl.vx_val   = vy - vx;
                        ctl.wr_flag  = 1'b1;
                        ctl.flag_val = (vy >= vx);
                    end
                    ALU_SHL:
                    begin
                        ctl.vx_val   = {vx[6:0], 1'b0};
                        ctl.wr_flag  = 1'b1;
                        ctl.flag_val = vx[7];
                    end
                    default:
                    begin
                        ctl.wr_vx  = 1'b0;
                        ctl.status = STAT_UNSUP;
                    end
                endcase
            end
            GRP_LOAD_INDEX:
            begin
                ctl.set_index = 1'b1;
                ctl.index_val = nnn;
            end
            GRP_JUMP_V0:     pc_next = PC_W'(jv0);
            GRP_RANDOM:
            begin
                ctl.wr_vx  = 1'b1;
                ctl.vx_val = random_byte & nn;
            end
            GRP_MISC:
            begin
                case (nn)
                    MISC_GET_DELAY:
                    begin
                        ctl.wr_vx  = 1'b1;
                        ctl.vx_val = delay;
                    end
                    MISC_SET_DELAY: ctl.set_delay = 1'b1;
                    // sound timer has no observable effect here
                    MISC_SET_SOUND: ctl.status = STAT_OK;
                    MISC_ADD_INDEX:
                    begin
                        ctl.set_index = 1'b1;
                        ctl.index_val = index + {4'b0000, vx};
                    end
                    MISC_FONT:
                    begin
                        ctl.set_index = 1'b1;
                        ctl.index_val = font_base + 12'({vx[3:0], 2'b00})
                                      + 12'(vx[3:0]);
                    end
                    MISC_BCD:  ctl.do_bcd  = 1'b1;
                    MISC_SAVE: ctl.do_save = 1'b1;
                    MISC_LOAD: ctl.do_load = 1'b1;
                    default:   ctl.status  = STAT_UNSUP;
                endcase
            end
            default:         ctl.status = STAT_UNSUP;
        endcase
    end

endmodule

@@ rtl/core/bytecode_vm_instruction_executor_core.sv @@
// Top level of the byte-code instruction executor: sequencer around the byte
// memory and the register/stack file. Depends on bve_pkg, bve_ram, bve_alu.
//
// Usage: an input word (operation, address, data, random_byte) is taken when
// in_valid and in_ready are both high; exactly one result word follows on the
// out_valid/out_ready channel. The user writes font_base through cfg_write
// and cfg_data only while the block is idle; the block does not enforce it.
// States per operation: write ST_WR, read ST_RD and ST_RDW, unknown operation
// ST_DONE directly, execute ST_F0..ST_RY and ST_EXEC, then ST_FLAG for a flag
// write, ST_BCD1 and ST_BCD2 for a BCD store, ST_SAVE or ST_LOAD for block
// save or load of V0..Vx. in_ready rises again at the same edge that loads
// the result. Execution is paced by the single read port of each memory:
// the two instruction bytes and three register operands are fetched one per
// cycle. One item is in work at a time; a new word is accepted while the
// previous result still waits, and the sequencer holds its finished result
// until the output register is free, so a stalled receiver stops the block.
// Reset: program counter 512, registers, index, stack depth and delay zero,
// output empty. Byte memory and return stack are undefined until written.
module bytecode_vm_instruction_executor_core
    import bve_pkg::*;
#(
    parameter int MEMORY_BYTES = MEMORY_BYTES_DEF,
    parameter int STACK_DEPTH  = STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [11:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  operation,
    input  logic [11:0] address,
    input  logic [7:0]  data,
    input  logic [7:0]  random_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  read_data,
    output logic [11:0] program_counter,
    output logic [15:0] opcode,
    output logic [1:0]  status,
    output logic        clear_display
);

    localparam int MEM_AW   = $clog2(MEMORY_BYTES);
    localparam int RF_DEPTH = NUM_REGS + STACK_DEPTH;
    localparam int RF_AW    = $clog2(RF_DEPTH);
    localparam int SD_W     = $clog2(STACK_DEPTH + 1);

    typedef enum logic [15:0] {
        ST_IDLE = 16'h0001,
        ST_WR   = 16'h0002,
        ST_RD   = 16'h0004,
        ST_RDW  = 16'h0008,
        ST_F0   = 16'h0010,
        ST_F1   = 16'h0020,
        ST_F2   = 16'h0040,
        ST_RX   = 16'h0080,
        ST_RY   = 16'h0100,
        ST_EXEC = 16'h0200,
        ST_FLAG = 16'h0400,
        ST_BCD1 = 16'h0800,
        ST_BCD2 = 16'h1000,
        ST_SAVE = 16'h2000,
        ST_LOAD = 16'h4000,
        ST_DONE = 16'h8000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Architectural and control registers
    logic [MEM_AW-1:0]   pc_reg;
    logic [11:0]         index_reg;
    logic [SD_W-1:0]     depth_reg;
    logic [7:0]          delay_reg;
    logic [11:0]         font_reg;
    logic [NUM_REGS-1:0] valid_reg;
    logic                rf_hit_reg;
    logic                out_valid_reg;

    // Item payload and working registers
    logic [1:0]  oper_reg;
    logic [11:0] addr_reg;
    logic [7:0]  data_reg;
    logic [7:0]  rnd_reg;
    logic [7:0]  hi_reg;
    logic [15:0] opcode_reg;
    logic [7:0]  vx_reg;
    logic [7:0]  vy_reg;
    logic        flag_reg;
    logic [3:0]  cnt_reg;
    logic [7:0]  res_rd_reg;
    logic [1:0]  res_status_reg;
    logic        res_clear_reg;
    logic [7:0]  out_rd_reg;
    logic [11:0] out_pc_reg;
    logic [15:0] out_op_reg;
    logic [1:0]  out_status_reg;
    logic        out_clear_reg;

    // Memory ports
    logic              pm_we;
    logic [MEM_AW-1:0] pm_waddr;
    logic [7:0]        pm_wdata;
    logic [MEM_AW-1:0] pm_raddr;
    logic [7:0]        pm_rdata;
    logic              rf_we;
    logic [RF_AW-1:0]  rf_waddr;
    logic [MEM_AW-1:0] rf_wdata;
    logic [RF_AW-1:0]  rf_raddr;
    logic [MEM_AW-1:0] rf_rdata;
    logic [MEM_AW-1:0] rf_val;

    logic              accept;
    logic              out_load;
    logic [3:0]        x_sel;
    logic [11:0]       bcd;
    logic [MEM_AW-1:0] idx_addr;
    logic [RF_AW-1:0]  stack_top;
    logic [RF_AW-1:0]  stack_free;
    logic              stack_full;
    logic              stack_empty;
    exec_ctl_t         ctl;
    logic [MEM_AW-1:0] pc_next;

    assign accept      = in_valid && in_ready;
    assign in_ready    = (state_reg == ST_IDLE);
    assign out_load    = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign x_sel       = opcode_reg[11:8];
    assign bcd         = bcd_digits(vx_reg);
    assign idx_addr    = MEM_AW'(index_reg);
    assign stack_full  = (depth_reg >= SD_W'(STACK_DEPTH));
    assign stack_empty = (depth_reg == '0);
    assign stack_free  = RF_AW'(NUM_REGS) + RF_AW'(depth_reg);
    assign stack_top   = stack_empty ? RF_AW'(NUM_REGS)
                                     : RF_AW'(NUM_REGS) + RF_AW'(depth_reg - SD_W'(1));
    // Registers never written read as zero
    assign rf_val      = rf_hit_reg ? rf_rdata : '0;

    bve_ram #(
        .WIDTH (8),
        .DEPTH (MEMORY_BYTES)
    ) u_prog_mem (
        .clk   (clk),
        .we    (pm_we),
        .waddr (pm_waddr),
        .wdata (pm_wdata),
        .raddr (pm_raddr),
        .rdata (pm_rdata)
    );

    // V0..VF at the bottom, return stack above
    bve_ram #(
        .WIDTH (MEM_AW),
        .DEPTH (RF_DEPTH)
    ) u_reg_file (
        .clk   (clk),
        .we    (rf_we),
        .waddr (rf_waddr),
        .wdata (rf_wdata),
        .raddr (rf_raddr),
        .rdata (rf_rdata)
    );

    bve_alu #(
        .PC_W (MEM_AW)
    ) u_alu (
        .opcode      (opcode_reg),
        .vx          (vx_reg),
        .vy          (vy_reg),
        .aux         (rf_val),
        .pc          (pc_reg),
        .index       (index_reg),
        .font_base   (font_reg),
        .delay       (delay_reg),
        .random_byte (rnd_reg),
        .stack_full  (stack_full),
        .stack_empty (stack_empty),
        .ctl         (ctl),
        .pc_next     (pc_next)
    );

    // Sequencer: memory port steering and next state
    always_comb
    begin
        state_next = state_reg;
        pm_we      = 1'b0;
        pm_waddr   = '0;
        pm_wdata   = '0;
        pm_raddr   = '0;
        rf_we      = 1'b0;
        rf_waddr   = '0;
        rf_wdata   = '0;
        rf_raddr   = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (operation)
                        OPER_WRITE: state_next = ST_WR;
                        OPER_READ:  state_next = ST_RD;
                        OPER_EXEC:  state_next = ST_F0;
                        default:    state_next = ST_DONE;
                    endcase
                end
            end
            ST_WR:
            begin
                pm_we      = 1'b1;
                pm_waddr   = MEM_AW'(addr_reg);
                pm_wdata   = data_reg;
                state_next = ST_DONE;
            end
            ST_RD:
            begin
                pm_raddr   = MEM_AW'(addr_reg);
                state_next = ST_RDW;
            end
            ST_RDW: state_next = ST_DONE;
            ST_F0:
            begin
                pm_raddr   = pc_reg;
                state_next = ST_F1;
            end
            ST_F1:
            begin
                pm_raddr   = pc_reg + MEM_AW'(1);
                state_next = ST_F2;
            end
            ST_F2:
            begin
                rf_raddr   = RF_AW'(hi_reg[3:0]);
                state_next = ST_RX;
            end
            ST_RX:
            begin
                rf_raddr   = RF_AW'(opcode_reg[7:4]);
                state_next = ST_RY;
            end
            ST_RY:
            begin
                rf_raddr   = (opcode_reg[15:12] == GRP_JUMP_V0) ? '0 : stack_top;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                if (ctl.wr_vx)
                begin
                    rf_we    = 1'b1;
                    rf_waddr = RF_AW'(x_sel);
                    rf_wdata = MEM_AW'(ctl.vx_val);
                end
                else if (ctl.push)
                begin
                    rf_we    = 1'b1;
                    rf_waddr = stack_free;
                    rf_wdata = pc_reg;
                end
                if (ctl.do_bcd)
                begin
                    pm_we    = 1'b1;
                    pm_waddr = idx_addr;
                    pm_wdata = {4'b0000, bcd[11:8]};
                end
                if (ctl.do_save)
                begin
                    rf_raddr = '0;
                end
                if (ctl.do_load)
                begin
                    pm_raddr = idx_addr;
                end
                if (ctl.wr_flag)
                begin
                    state_next = ST_FLAG;
                end
                else if (ctl.do_bcd)
                begin
                    state_next = ST_BCD1;
                end
                else if (ctl.do_save)
                begin
                    state_next = ST_SAVE;
                end
                else if (ctl.do_load)
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FLAG:
            begin
                rf_we      = 1'b1;
                rf_waddr   = RF_AW'(FLAG_REG);
                rf_wdata   = MEM_AW'(flag_reg);
                state_next = ST_DONE;
            end
            ST_BCD1:
            begin
                pm_we      = 1'b1;
                pm_waddr   = idx_addr + MEM_AW'(1);
                pm_wdata   = {4'b0000, bcd[7:4]};
                state_next = ST_BCD2;
            end
            ST_BCD2:
            begin
                pm_we      = 1'b1;
                pm_waddr   = idx_addr + MEM_AW'(2);
                pm_wdata   = {4'b0000, bcd[3:0]};
                state_next = ST_DONE;
            end
            ST_SAVE:
            begin
                // store Vcnt while reading the next register
                pm_we    = 1'b1;
                pm_waddr = idx_addr + MEM_AW'(cnt_reg);
                pm_wdata = rf_val[7:0];
                rf_raddr = RF_AW'(cnt_reg + 4'd1);
                if (cnt_reg == x_sel)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_LOAD:
            begin
                // load Vcnt while reading the next byte
                rf_we    = 1'b1;
                rf_waddr = RF_AW'(cnt_reg);
                rf_wdata = MEM_AW'(pm_rdata);
                pm_raddr = idx_addr + MEM_AW'({1'b0, cnt_reg} + 5'd1);
                if (cnt_reg == x_sel)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pc_reg        <= MEM_AW'(PC_RESET);
            index_reg     <= '0;
            depth_reg     <= '0;
            delay_reg     <= '0;
            font_reg      <= '0;
            valid_reg     <= '0;
            rf_hit_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rf_hit_reg <= (rf_raddr < RF_AW'(NUM_REGS)) ? valid_reg[rf_raddr[3:0]] : 1'b1;
            if (cfg_write)
            begin
                font_reg <= cfg_data;
            end
            if (rf_we && (rf_waddr < RF_AW'(NUM_REGS)))
            begin
                valid_reg[rf_waddr[3:0]] <= 1'b1;
            end
            if (state_reg == ST_EXEC)
            begin
                pc_reg <= pc_next;
                if (ctl.set_index)
                begin
                    index_reg <= ctl.index_val;
                end
                if (ctl.set_delay)
                begin
                    delay_reg <= vx_reg;
                end
                if (ctl.push)
                begin
                    depth_reg <= depth_reg + SD_W'(1);
                end
                else if (ctl.pop)
                begin
                    depth_reg <= depth_reg - SD_W'(1);
                end
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload and working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            oper_reg       <= operation;
            addr_reg       <= address;
            data_reg       <= data;
            rnd_reg        <= random_byte;
            opcode_reg     <= '0;
            res_rd_reg     <= '0;
            res_status_reg <= STAT_OK;
            res_clear_reg  <= 1'b0;
        end
        case (state_reg)
            ST_RDW: res_rd_reg <= pm_rdata;
            ST_F1:  hi_reg     <= pm_rdata;
            ST_F2:  opcode_reg <= {hi_reg, pm_rdata};
            ST_RX:  vx_reg     <= rf_val[7:0];
            ST_RY:  vy_reg     <= rf_val[7:0];
            ST_EXEC:
            begin
                res_status_reg <= ctl.status;
                res_clear_reg  <= ctl.clear;
                flag_reg       <= ctl.flag_val;
                cnt_reg        <= '0;
            end
            ST_SAVE: cnt_reg <= cnt_reg + 4'd1;
            ST_LOAD: cnt_reg <= cnt_reg + 4'd1;
            default: cnt_reg <= cnt_reg;
        endcase
        if (out_load)
        begin
            out_rd_reg     <= (oper_reg == OPER_READ) ? res_rd_reg : 8'd0;
            out_pc_reg     <= 12'(pc_reg);
            out_op_reg     <= opcode_reg;
            out_status_reg <= res_status_reg;
            out_clear_reg  <= res_clear_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign read_data       = out_rd_reg;
    assign program_counter = out_pc_reg;
    assign opcode          = out_op_reg;
    assign status          = out_status_reg;
    assign clear_display   = out_clear_reg;

    // Return stack never grows past its depth
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= SD_W'(STACK_DEPTH))
        else $error("return stack depth out of range");

    // One item in work at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("second item accepted while busy");

    // Underflow only reported for a return
    a_underflow_src: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STAT_UNDERFLOW) |-> (opcode == OPW_RETURN))
        else $error("underflow status without return");

    // Clear flag only for the clear-screen word
    a_clear_src: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clear_display) |-> (opcode == OPW_CLEAR))
        else $error("clear flag without clear-screen word");

endmodule

@@ tb/sv/bytecode_vm_instruction_executor_checker.sv @@
// Scoreboard for the byte-code instruction executor: watches both word channels,
// predicts every result from its own machine state and compares field by field.
// Depends on bve_pkg for operation, status and instruction codes.
module bytecode_vm_instruction_executor_checker
    import bve_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_write,
    input  logic [11:0]   cfg_data,
    input  logic          in_valid,
    input  logic          in_ready,
    input  logic [1:0]    operation,
    input  logic [11:0]   address,
    input  logic [7:0]    data,
    input  logic [7:0]    random_byte,
    input  logic          out_valid,
    input  logic          out_ready,
    input  logic [7:0]    read_data,
    input  logic [11:0]   program_counter,
    input  logic [15:0]   opcode,
    input  logic [1:0]    status,
    input  logic          clear_display,
    output logic [11:0]   pc_now,
    output logic [11:0]   index_now,
    output logic [4095:0] mem_known,
    output int            pending,
    output int            fail_count
);

    typedef struct packed {
        logic [7:0]  rd;
        logic [11:0] pc;
        logic [15:0] op;
        logic [1:0]  st;
        logic        clr;
    } vm_result_t;

    // Machine state as the executor should hold it
    logic [7:0]  mem [0:4095];
    logic [7:0]  vreg [0:15];
    logic [11:0] stack_mem [0:15];
    logic [11:0] ireg;
    logic [11:0] pcreg;
    int          depth;
    logic [7:0]  delay_cnt;
    logic [7:0]  sound_cnt;
    logic [11:0] font_addr;

    vm_result_t expected_results[$];

    assign pc_now    = pcreg;
    assign index_now = ireg;
    assign pending   = expected_results.size();

    task automatic store_byte(input logic [11:0] a, input logic [7:0] v);
        mem[a] = v;
        mem_known[a] = 1'b1;
    endtask

    // Execute one instruction word against the predicted state
    task automatic exec_word(input logic [15:0] op, input logic [7:0] rnd,
                             output logic [1:0] st, output logic clr);
        logic [3:0]  x;
        logic [3:0]  y;
        logic [7:0]  nn;
        logic [11:0] nnn;
        logic [7:0]  vx;
        logic [7:0]  vy;
        logic [8:0]  sum;
        logic [7:0]  r;
        logic        f;
        logic        has_flag;
        logic        ok;
        x = op[11:8];
        y = op[7:4];
        nn = op[7:0];
        nnn = op[11:0];
        vx = vreg[x];
        vy = vreg[y];
        st = STAT_OK;
        clr = 1'b0;
        case (op[15:12])
            GRP_SYS: begin
                if (op == OPW_CLEAR) begin
                    clr = 1'b1;
                    pcreg = pcreg + 12'd2;
                end
                else if (op == OPW_RETURN) begin
                    if (depth == 0) begin
                        st = STAT_UNDERFLOW;
                        pcreg = pcreg + 12'd2;
                    end
                    else begin
                        depth = depth - 1;
                        pcreg = stack_mem[depth] + 12'd2;
                    end
                end
                else begin
                    st = STAT_UNSUP;
                    pcreg = pcreg + 12'd2;
                end
            end
            GRP_JUMP: pcreg = nnn;
            GRP_CALL: begin
                if (depth >= 16) begin
                    st = STAT_OVERFLOW;
                    pcreg = pcreg + 12'd2;
                end
                else begin
                    stack_mem[depth] = pcreg;
                    depth = depth + 1;
                    pcreg = nnn;
                end
            end
            GRP_SKIP_EQ_IMM: pcreg = pcreg + ((vx == nn) ? 12'd4 : 12'd2);
            GRP_SKIP_NE_IMM: pcreg = pcreg + ((vx != nn) ? 12'd4 : 12'd2);
            GRP_SKIP_EQ_REG: pcreg = pcreg + ((vx == vy) ? 12'd4 : 12'd2);
            GRP_SKIP_NE_REG: pcreg = pcreg + ((vx != vy) ? 12'd4 : 12'd2);
            GRP_LOAD_IMM: begin
                vreg[x] = nn;
                pcreg = pcreg + 12'd2;
            end
            GRP_ADD_IMM: begin
                vreg[x] = vx + nn;
                pcreg = pcreg + 12'd2;
            end
            GRP_ALU: begin
                has_flag = 1'b1;
                ok = 1'b1;
                f = 1'b0;
                r = 8'd0;
                case (op[3:0])
                    ALU_MOV: begin r = vy; has_flag = 1'b0; end
                    ALU_OR:  begin r = vx | vy; has_flag = 1'b0; end
                    ALU_AND: begin r = vx & vy; has_flag = 1'b0; end
                    ALU_XOR: begin r = vx ^ vy; has_flag = 1'b0; end
                    ALU_ADD: begin sum = {1'b0, vx} + {1'b0, vy}; r = sum[7:0]; f = sum[8]; end
                    ALU_SUB: begin r = vx - vy; f = (vx >= vy); end
                    ALU_SHR: begin r = vx >> 1; f = vx[0]; end
                    ALU_SUBN: begin r = vy - vx; f = (vy >= vx); end
                    ALU_SHL: begin r = vx << 1; f = vx[7]; end
                    default: ok = 1'b0;
                endcase
                if (!ok)
                    st = STAT_UNSUP;
                else begin
                    // flag goes last so it wins when X is the flag register
                    vreg[x] = r;
                    if (has_flag)
                        vreg[FLAG_REG] = {7'd0, f};
                end
                pcreg = pcreg + 12'd2;
            end
            GRP_LOAD_INDEX: begin
                ireg = nnn;
                pcreg = pcreg + 12'd2;
            end
            GRP_JUMP_V0: pcreg = nnn + {4'd0, vreg[0]};
            GRP_RANDOM: begin
                vreg[x] = rnd & nn;
                pcreg = pcreg + 12'd2;
            end
            GRP_MISC: begin
                case (nn)
                    MISC_GET_DELAY: vreg[x] = delay_cnt;
                    MISC_SET_DELAY: delay_cnt = vx;
                    MISC_SET_SOUND: sound_cnt = vx;
                    MISC_ADD_INDEX: ireg = ireg + {4'd0, vx};
                    MISC_FONT:      ireg = font_addr + 12'd5 * {8'd0, vx[3:0]};
                    MISC_BCD: begin
                        store_byte(ireg, vx / 8'd100);
                        store_byte(ireg + 12'd1, (vx / 8'd10) % 8'd10);
                        store_byte(ireg + 12'd2, vx % 8'd10);
                    end
                    MISC_SAVE:
                        for (int i = 0; i <= x; i++)
                            store_byte(ireg + 12'(i), vreg[i]);
                    MISC_LOAD:
                        for (int i = 0; i <= x; i++)
                            vreg[i] = mem[ireg + 12'(i)];
                    default: st = STAT_UNSUP;
                endcase
                pcreg = pcreg + 12'd2;
            end
            default: begin
                st = STAT_UNSUP;
                pcreg = pcreg + 12'd2;
            end
        endcase
    endtask

    // Predict on accepted input words, compare on accepted output words
    always @(posedge clk) begin
        vm_result_t e;
        vm_result_t got;
        if (!rst_n) begin
            for (int i = 0; i < 16; i++) begin
                vreg[i] = 8'd0;
                stack_mem[i] = 12'd0;
            end
            mem_known = '0;
            ireg = 12'd0;
            pcreg = 12'(PC_RESET);
            depth = 0;
            delay_cnt = 8'd0;
            sound_cnt = 8'd0;
            font_addr = 12'd0;
            fail_count = 0;
            expected_results.delete();
        end
        else begin
            if (cfg_write)
                font_addr = cfg_data;
            if (in_valid && in_ready) begin
                e = '0;
                case (operation)
                    OPER_WRITE: store_byte(address, data);
                    OPER_READ:  e.rd = mem[address];
                    OPER_EXEC: begin
                        e.op = {mem[pcreg], mem[pcreg + 12'd1]};
                        exec_word(e.op, random_byte, e.st, e.clr);
                    end
                    default: ;
                endcase
                e.pc = pcreg;
                expected_results.push_back(e);
            end
            if (out_valid && out_ready) begin
                got = '{read_data, program_counter, opcode, status, clear_display};
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected: pc %h op %h", program_counter,
                           opcode);
                    fail_count++;
                end
                else begin
                    e = expected_results.pop_front();
                    if (got.rd !== e.rd) begin
                        $error("read_data: expected %h got %h", e.rd, got.rd);
                        fail_count++;
                    end
                    if (got.pc !== e.pc) begin
                        $error("program_counter: expected %h got %h", e.pc, got.pc);
                        fail_count++;
                    end
                    if (got.op !== e.op) begin
                        $error("opcode: expected %h got %h", e.op, got.op);
                        fail_count++;
                    end
                    if (got.st !== e.st) begin
                        $error("status: expected %0d got %0d", e.st, got.st);
                        fail_count++;
                    end
                    if (got.clr !== e.clr) begin
                        $error("clear_display: expected %b got %b", e.clr, got.clr);
                        fail_count++;
                    end
                end
            end
        end
    end

endmodule

@@ tb/sv/bytecode_vm_instruction_executor_core_tb.sv @@
// Testbench top for the byte-code instruction executor: clock, reset, word
// stimulus with random idling and the verdict. Depends on bve_pkg, the core
// and bytecode_vm_instruction_executor_checker.
module bytecode_vm_instruction_executor_core_tb;
    import bve_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int PHASE_WORDS   = 610;
    localparam int DRAIN_CYCLES  = 40;

    logic          clk = 1'b0;
    logic          rst_n = 1'b0;
    logic          cfg_write = 1'b0;
    logic [11:0]   cfg_data = '0;
    logic          in_valid = 1'b0;
    logic          in_ready;
    logic [1:0]    operation = '0;
    logic [11:0]   address = '0;
    logic [7:0]    data = '0;
    logic [7:0]    random_byte = '0;
    logic          out_valid;
    logic          out_ready = 1'b0;
    logic [7:0]    read_data;
    logic [11:0]   program_counter;
    logic [15:0]   opcode;
    logic [1:0]    status;
    logic          clear_display;
    logic [11:0]   pc_now;
    logic [11:0]   index_now;
    logic [4095:0] mem_known;
    int            pending;
    int            fail_count;

    int  send_idle = 0;
    int  recv_idle = 0;
    bit  hold_req = 0;
    int  words_sent = 0;
    int  execs_sent = 0;
    int  cycles = 0;
    int  call_burst = 0;
    int  ret_burst = 0;

    bytecode_vm_instruction_executor_core u_top (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
        .address(address), .data(data), .random_byte(random_byte),
        .out_valid(out_valid), .out_ready(out_ready), .read_data(read_data),
        .program_counter(program_counter), .opcode(opcode), .status(status),
        .clear_display(clear_display)
    );

    bytecode_vm_instruction_executor_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .operation(operation),
        .address(address), .data(data), .random_byte(random_byte),
        .out_valid(out_valid), .out_ready(out_ready), .read_data(read_data),
        .program_counter(program_counter), .opcode(opcode), .status(status),
        .clear_display(clear_display), .pc_now(pc_now), .index_now(index_now),
        .mem_known(mem_known), .pending(pending), .fail_count(fail_count)
    );

    always #6 clk = ~clk;

    // Bound the run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("bytecode_vm_instruction_executor_core_tb failed");
            $finish;
        end
    end

    // Receiver: random back-pressure, plus one long hold when asked
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    // Offer one word at a falling edge and hold it until accepted; return at
    // the next falling edge so the checker has taken the accepted word
    task automatic send_word(input logic [1:0] oper, input logic [11:0] addr,
                             input logic [7:0] dat);
        while ($urandom_range(0, 99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        operation <= oper;
        address <= addr;
        data <= dat;
        random_byte <= 8'($urandom);
        do @(posedge clk); while (!in_ready);
        words_sent++;
        @(negedge clk);
    endtask

    // Place an instruction at the predicted program counter and run it
    task automatic run_instr(input logic [15:0] op);
        logic [11:0] a;
        if (op[15:12] == GRP_MISC && op[7:0] == MISC_LOAD)
        begin
            for (int i = 0; i <= op[11:8]; i++)
            begin
                a = index_now + 12'(i);
                if (!mem_known[a])
                begin
                    send_word(OPER_WRITE, a, 8'($urandom));
                end
            end
        end
        send_word(OPER_WRITE, pc_now, op[15:8]);
        send_word(OPER_WRITE, pc_now + 12'd1, op[7:0]);
        send_word(OPER_EXEC, 12'($urandom), 8'($urandom));
        execs_sent++;
    endtask

    function automatic logic [15:0] pick_instr();
        logic [15:0] op;
        int k;
        op = 16'($urandom);
        k = $urandom_range(0, 99);
        if (call_burst > 0)
        begin
            call_burst--;
            return {GRP_CALL, op[11:0]};
        end
        if (ret_burst > 0)
        begin
            ret_burst--;
            return OPW_RETURN;
        end
        if (k < 5) return OPW_CLEAR;
        if (k < 14) return OPW_RETURN;
        if (k < 16) return {GRP_SYS, op[11:0]};
        if (k < 25) return {GRP_CALL, op[11:0]};
        if (k < 45)
        begin
            case ($urandom_range(0, 9))
                0: op[3:0] = ALU_MOV;
                1: op[3:0] = ALU_OR;
                2: op[3:0] = ALU_AND;
                3: op[3:0] = ALU_XOR;
                4: op[3:0] = ALU_ADD;
                5: op[3:0] = ALU_SUB;
                6: op[3:0] = ALU_SHR;
                7: op[3:0] = ALU_SUBN;
                8: op[3:0] = ALU_SHL;
                default: ;
            endcase
            return {GRP_ALU, op[11:0]};
        end
        if (k < 65)
        begin
            case ($urandom_range(0, 8))
                0: op[7:0] = MISC_GET_DELAY;
                1: op[7:0] = MISC_SET_DELAY;
                2: op[7:0] = MISC_SET_SOUND;
                3: op[7:0] = MISC_ADD_INDEX;
                4: op[7:0] = MISC_FONT;
                5: op[7:0] = MISC_BCD;
                6: op[7:0] = MISC_SAVE;
                7: op[7:0] = MISC_LOAD;
                default: ;
            endcase
            return {GRP_MISC, op[11:0]};
        end
        if (k < 75) return {GRP_LOAD_IMM, op[11:0]};
        return op;
    endfunction

    // Random mix of memory traffic and instructions
    task automatic random_phase(input int words);
        int stop_at;
        int k;
        logic [11:0] a;
        stop_at = words_sent + words;
        while (words_sent < stop_at)
        begin
            k = $urandom_range(0, 99);
            a = 12'($urandom);
            if (k < 10)
            begin
                send_word(OPER_WRITE, a, 8'($urandom));
            end
            else if (k < 20)
            begin
                if (!mem_known[a])
                begin
                    send_word(OPER_WRITE, a, 8'($urandom));
                end
                send_word(OPER_READ, a, 8'($urandom));
            end
            else if (k < 23)
            begin
                send_word(OPER_NOP, a, 8'($urandom));
            end
            else
            begin
                if (call_burst == 0 && ret_burst == 0 && $urandom_range(0, 59) == 0)
                begin
                    call_burst = 18;
                    ret_burst = 18;
                end
                run_instr(pick_instr());
            end
        end
    endtask

    // Let the block drain, then load the font base
    task automatic set_font(input logic [11:0] v);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data <= v;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    initial
    begin
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: screen clear, empty return, call and return, flags, skip, font
        run_instr(OPW_CLEAR);
        run_instr(OPW_RETURN);
        run_instr({GRP_CALL, 12'h300});
        run_instr(OPW_RETURN);
        run_instr({GRP_LOAD_IMM, 4'hF, 8'hFF});
        run_instr({GRP_ALU, 4'hF, 4'hF, ALU_ADD});
        run_instr({GRP_SKIP_EQ_REG, 4'h1, 4'h2, 4'h7});
        run_instr({GRP_MISC, 4'hF, MISC_FONT});
        run_instr(16'h0123);
        send_word(OPER_NOP, 12'hFFF, 8'hFF);
        send_word(OPER_WRITE, 12'hFFF, 8'hFF);
        send_word(OPER_READ, 12'hFFF, 8'h00);

        set_font(12'hFFF);
        send_idle = 36;
        recv_idle = 68;
        random_phase(PHASE_WORDS);

        set_font(12'h000);
        send_idle = 68;
        recv_idle = 36;
        random_phase(PHASE_WORDS);

        set_font(12'($urandom));
        send_idle = 0;
        recv_idle = 0;
        random_phase(PHASE_WORDS / 2);
        hold_req = 1;
        random_phase(PHASE_WORDS / 2);

        // Drain and report
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d words, %0d instructions, three font bases", words_sent,
                 execs_sent);
        if (fail_count == 0)
            $display("bytecode_vm_instruction_executor_core_tb passed");
        else
            $display("bytecode_vm_instruction_executor_core_tb failed");
        $finish;
    end

endmodule
